[hdl/rrsp_pkg.sv]
// Shared types and constants for the RESP2 reply stream parser.
`default_nettype none

package rrsp_pkg;

  // Default and widths
  localparam int MAX_NEST_DEF = 8;
  localparam int DEPTH_W      = 4;
  localparam int CNT_W        = 31;
  localparam int BYTE_W       = 8;
  localparam int NUM_W        = 32;

  // Byte roles
  localparam logic [2:0] ROLE_MARKER = 3'd0;
  localparam logic [2:0] ROLE_LINE   = 3'd1;
  localparam logic [2:0] ROLE_NUM    = 3'd2;
  localparam logic [2:0] ROLE_BODY   = 3'd3;
  localparam logic [2:0] ROLE_TERM   = 3'd4;

  // Element types
  localparam logic [2:0] TYPE_STATUS = 3'd0;
  localparam logic [2:0] TYPE_ERROR  = 3'd1;
  localparam logic [2:0] TYPE_INT    = 3'd2;
  localparam logic [2:0] TYPE_BULK   = 3'd3;
  localparam logic [2:0] TYPE_ARRAY  = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
  localparam logic [2:0] ERR_BAD_NUM  = 3'd2;
  localparam logic [2:0] ERR_NO_CRLF  = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP = 3'd4;

  // Request from the byte parser to the count stack
  typedef struct packed {
    logic             push;
    logic             finish;
    logic             clear;
    logic [CNT_W-1:0] count;
  } stk_cmd_t;

  // Stack status seen by the byte parser
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               full;
    logic               reply_done;
  } stk_stat_t;

  // One tagged result
  typedef struct packed {
    logic [BYTE_W-1:0]       byte_value;
    logic [2:0]              byte_role;
    logic [2:0]              element_type;
    logic [DEPTH_W-1:0]      nest_level;
    logic signed [NUM_W-1:0] header_number;
    logic                    number_valid;
    logic                    is_nil;
    logic                    element_done;
    logic                    reply_done;
    logic [2:0]              error_code;
  } result_t;

endpackage

`default_nettype wire

[hdl/rrsp_nest_stack.sv]
// Stack of pending array element counts with multi-level pop.
`default_nettype none

module rrsp_nest_stack #(
  parameter int MAX_NEST = rrsp_pkg::MAX_NEST_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire rrsp_pkg::stk_cmd_t  cmd,
  output rrsp_pkg::stk_stat_t      stat
);

  localparam int IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic [rrsp_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [rrsp_pkg::CNT_W-1:0]   cnt_r [MAX_NEST];
  logic [MAX_NEST-1:0]          one_r;
  logic                         found;
  logic [IDX_W-1:0]             tgt;
  logic [rrsp_pkg::CNT_W-1:0]   tgt_cnt;
  logic [IDX_W-1:0]             push_idx;

  // Find the innermost live level whose count stays above zero after this element
  always_comb begin
    found = 1'b0;
    tgt   = '0;
    for (int k = 0; k < MAX_NEST; k++) begin
      if ((rrsp_pkg::DEPTH_W'(k) < depth_r) && !one_r[k]) begin
        found = 1'b1;
        tgt   = IDX_W'(k);
      end
    end
  end

  assign tgt_cnt  = cnt_r[tgt];
  assign push_idx = depth_r[IDX_W-1:0];

  // Next depth
  always_comb begin
    depth_nxt = depth_r;
    if (cmd.clear) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt = depth_r + 1'b1;
    end else if (cmd.finish) begin
      depth_nxt = found ? (rrsp_pkg::DEPTH_W'(tgt) + 1'b1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (step) begin
      depth_r <= depth_nxt;
    end
  end

  // Count storage: push writes the new top, finish counts down the target level
  always_ff @(posedge clk) begin
    if (step && !cmd.clear) begin
      if (cmd.push) begin
        cnt_r[push_idx] <= cmd.count;
        one_r[push_idx] <= (cmd.count == rrsp_pkg::CNT_W'(1));
      end else if (cmd.finish && found) begin
        cnt_r[tgt] <= tgt_cnt - 1'b1;
        one_r[tgt] <= (tgt_cnt == rrsp_pkg::CNT_W'(2));
      end
    end
  end

  assign stat.depth      = depth_r;
  assign stat.full       = (depth_r >= rrsp_pkg::DEPTH_W'(MAX_NEST));
  assign stat.reply_done = !found;

endmodule

`default_nettype wire

[hdl/rrsp_byte_parse.sv]
// Per-byte RESP2 phase tracking, header number decode and result tagging.
`default_nettype none

module rrsp_byte_parse (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [rrsp_pkg::BYTE_W-1:0] data_byte,
  input  wire rrsp_pkg::stk_stat_t         stat,
  output rrsp_pkg::stk_cmd_t               cmd,
  output rrsp_pkg::result_t                res
);

  // Parse phases
  localparam logic [3:0] PH_TYPE      = 4'd0;
  localparam logic [3:0] PH_LINE      = 4'd1;
  localparam logic [3:0] PH_LINE_LF   = 4'd2;
  localparam logic [3:0] PH_NUM_START = 4'd3;
  localparam logic [3:0] PH_NUM_SIGN  = 4'd4;
  localparam logic [3:0] PH_NUM_DIG   = 4'd5;
  localparam logic [3:0] PH_NUM_LF    = 4'd6;
  localparam logic [3:0] PH_BODY      = 4'd7;
  localparam logic [3:0] PH_BODY_CR   = 4'd8;
  localparam logic [3:0] PH_BODY_LF   = 4'd9;

  // Protocol characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int CW = rrsp_pkg::CNT_W;
  localparam int PW = CW + 4;

  logic [3:0]    phase_r, phase_nxt;
  logic [2:0]    type_r, type_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] body_r, body_nxt;

  logic          digit;
  logic [3:0]    dval;
  logic [PW-1:0] prod;
  logic          ovf;
  logic          neg_eff;
  logic [CW-1:0] body_dec;

  logic [2:0]                     role, etype, err;
  logic signed [rrsp_pkg::NUM_W-1:0] hnum;
  logic                           nvalid, nil, edone, rdone;
  logic                           push, finish;

  // Digit value and next accumulator (times ten as two shifts)
  assign digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign dval     = data_byte[3:0];
  assign prod     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {{(PW-4){1'b0}}, dval};
  assign ovf      = |prod[PW-1:CW];
  assign neg_eff  = neg_r && (acc_r != '0);
  assign body_dec = body_r - {{(CW-1){1'b0}}, (body_r != '0)};

  // Decode one byte against the current phase
  always_comb begin
    role      = rrsp_pkg::ROLE_TERM;
    etype     = type_r;
    err       = rrsp_pkg::ERR_NONE;
    hnum      = '0;
    nvalid    = 1'b0;
    nil       = 1'b0;
    edone     = 1'b0;
    rdone     = 1'b0;
    push      = 1'b0;
    finish    = 1'b0;
    phase_nxt = phase_r;
    type_nxt  = type_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    body_nxt  = body_r;

    unique case (phase_r)
      PH_TYPE: begin
        role = rrsp_pkg::ROLE_MARKER;
        unique case (data_byte)
          CH_PLUS:  etype = rrsp_pkg::TYPE_STATUS;
          CH_MINUS: etype = rrsp_pkg::TYPE_ERROR;
          CH_COLON: etype = rrsp_pkg::TYPE_INT;
          CH_DOLL:  etype = rrsp_pkg::TYPE_BULK;
          CH_STAR:  etype = rrsp_pkg::TYPE_ARRAY;
          default: begin
            etype = rrsp_pkg::TYPE_STATUS;
            err   = rrsp_pkg::ERR_BAD_TYPE;
          end
        endcase
        type_nxt  = etype;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = (etype >= rrsp_pkg::TYPE_BULK) ? PH_NUM_START : PH_LINE;
      end
      PH_LINE: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_LINE_LF;
        end else if (data_byte == CH_LF) begin
          err = rrsp_pkg::ERR_NO_CRLF;
        end else begin
          role = rrsp_pkg::ROLE_LINE;
        end
      end
      PH_LINE_LF, PH_BODY_LF: begin
        if (data_byte == CH_LF) begin
          edone     = 1'b1;
          finish    = 1'b1;
          rdone     = stat.reply_done;
          phase_nxt = PH_TYPE;
        end else begin
          err = rrsp_pkg::ERR_NO_CRLF;
        end
      end
      PH_NUM_START, PH_NUM_SIGN, PH_NUM_DIG: begin
        role = rrsp_pkg::ROLE_NUM;
        if (digit) begin
          if (ovf) begin
            err = rrsp_pkg::ERR_BAD_NUM;
          end else begin
            acc_nxt   = prod[CW-1:0];
            phase_nxt = PH_NUM_DIG;
          end
        end else if ((data_byte == CH_MINUS) && (phase_r == PH_NUM_START)) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_NUM_SIGN;
        end else if ((data_byte == CH_CR) && (phase_r == PH_NUM_DIG)) begin
          role    = rrsp_pkg::ROLE_TERM;
          neg_nxt = neg_eff;
          // Only minus one is a legal negative bulk length
          if ((type_r == rrsp_pkg::TYPE_BULK) && neg_eff && (acc_r != CW'(1))) begin
            err = rrsp_pkg::ERR_BAD_NUM;
          end else begin
            phase_nxt = PH_NUM_LF;
          end
        end else begin
          err = rrsp_pkg::ERR_BAD_NUM;
        end
      end
      PH_NUM_LF: begin
        if (data_byte != CH_LF) begin
          err = rrsp_pkg::ERR_NO_CRLF;
        end else if (type_r == rrsp_pkg::TYPE_BULK) begin
          nvalid = 1'b1;
          if (neg_r) begin
            hnum      = '1;
            nil       = 1'b1;
            edone     = 1'b1;
            finish    = 1'b1;
            rdone     = stat.reply_done;
            phase_nxt = PH_TYPE;
          end else begin
            hnum      = {1'b0, acc_r};
            body_nxt  = acc_r;
            phase_nxt = (acc_r == '0) ? PH_BODY_CR : PH_BODY;
          end
        end else if (neg_r || (acc_r == '0)) begin
          // Empty or nil array completes at once
          hnum      = neg_r ? '1 : '0;
          nvalid    = 1'b1;
          nil       = 1'b1;
          edone     = 1'b1;
          finish    = 1'b1;
          rdone     = stat.reply_done;
          phase_nxt = PH_TYPE;
        end else if (stat.full) begin
          err = rrsp_pkg::ERR_TOO_DEEP;
        end else begin
          hnum      = {1'b0, acc_r};
          nvalid    = 1'b1;
          push      = 1'b1;
          phase_nxt = PH_TYPE;
        end
      end
      PH_BODY: begin
        role     = rrsp_pkg::ROLE_BODY;
        body_nxt = body_dec;
        if (body_dec == '0) begin
          phase_nxt = PH_BODY_CR;
        end
      end
      PH_BODY_CR: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_BODY_LF;
        end else begin
          err = rrsp_pkg::ERR_NO_CRLF;
        end
      end
      default: begin
        err = rrsp_pkg::ERR_NO_CRLF;
      end
    endcase

    // Drop everything on an error and return to the top level
    if (err != rrsp_pkg::ERR_NONE) begin
      hnum      = '0;
      nvalid    = 1'b0;
      nil       = 1'b0;
      edone     = 1'b0;
      rdone     = 1'b0;
      push      = 1'b0;
      finish    = 1'b0;
      phase_nxt = PH_TYPE;
      type_nxt  = type_r;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      body_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= rrsp_pkg::TYPE_STATUS;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      body_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      body_r  <= body_nxt;
    end
  end

  assign cmd.push   = push;
  assign cmd.finish = finish;
  assign cmd.clear  = (err != rrsp_pkg::ERR_NONE);
  assign cmd.count  = acc_r;

  assign res.byte_value    = data_byte;
  assign res.byte_role     = role;
  assign res.element_type  = etype;
  assign res.nest_level    = stat.depth;
  assign res.header_number = hnum;
  assign res.number_valid  = nvalid;
  assign res.is_nil        = nil;
  assign res.element_done  = edone;
  assign res.reply_done    = rdone;
  assign res.error_code    = err;

endmodule

`default_nettype wire

[hdl/resp_reply_stream_parser_core.sv]
// Top level of the RESP2 reply stream parser: input and result registers around the parser.
//
//  channel | ports              | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_tvalid/tready   | tdata[7:0] data_byte
//  out     | out_tvalid/tready  | tdata byte_value, header_number; tuser tags;
//          |                    | tlast reply_done
//
// One byte per cycle sustained while out_tready stays high; each byte passes through the input
// register and then sits in the result register.
// Parsing state and the count stack update in the cycle a byte moves to the
// result register; the stack pops any number of finished arrays in that cycle.
// Reset (synchronous, active low) returns to waiting for a type byte at depth zero.
// A stall on out_tready holds both registers and lowers in_tready once both are full.
`default_nettype none

module resp_reply_stream_parser_core #(
  parameter int MAX_NEST = rrsp_pkg::MAX_NEST_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] byte_value, [39:8] header_number
  output logic [15:0]      out_tuser,  // [2:0] byte_role, [5:3] element_type,
                                       // [9:6] nest_level, [10] number_valid,
                                       // [11] is_nil, [12] element_done,
                                       // [15:13] error_code
  output logic             out_tlast   // reply_done
);

  logic                  in_valid_r;
  logic [7:0]            in_data_r;
  logic                  out_valid_r;
  rrsp_pkg::result_t     out_res_r;
  logic                  advance;
  rrsp_pkg::stk_cmd_t    cmd;
  rrsp_pkg::stk_stat_t   stat;
  rrsp_pkg::result_t     res;

  // Move a byte forward when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  rrsp_byte_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_data_r),
    .stat      (stat),
    .cmd       (cmd),
    .res       (res)
  );

  rrsp_nest_stack #(
    .MAX_NEST (MAX_NEST)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.header_number, out_res_r.byte_value};
  assign out_tuser  = {out_res_r.error_code, out_res_r.element_done,
                       out_res_r.is_nil, out_res_r.number_valid, out_res_r.nest_level,
                       out_res_r.element_type, out_res_r.byte_role};
  assign out_tlast  = out_res_r.reply_done;

endmodule

`default_nettype wire
